>>> rtl/core/ssd_pkg.sv
// Shared types, constants and the segment lookup for the decimal scan driver.
// Used by every module under rtl/core; depends on nothing.
package ssd_pkg;

  localparam int MaxDigits = 8;
  localparam int DigitW    = 4;
  localparam int NumW      = 27;
  localparam int CountW    = 4;
  localparam int PosW      = 3;
  localparam int StepW     = 5;
  localparam int TableW    = 40;
  localparam int CfgIdxW   = 4;
  localparam int SegW      = 8;

  localparam logic [StepW-1:0] ConvSteps = StepW'(NumW);

  localparam logic [CountW-1:0] CountReset   = CountW'(MaxDigits);
  localparam logic [TableW-1:0] TableLoReset = 40'h664F5B063F;
  localparam logic [TableW-1:0] TableHiReset = 40'h6F7F077D6D;
  localparam logic [SegW-1:0]   SegInvalid   = 8'h80;

  localparam logic [CfgIdxW-1:0] REG_DIGIT_COUNT    = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_COMMON_CATHODE = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_TABLE_LOW      = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_TABLE_HIGH     = 4'd3;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_SCAN = 1'b1;

  typedef logic [MaxDigits-1:0][DigitW-1:0] digits_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_status_t;

  function automatic logic [SegW-1:0] segment_of(
    input logic [DigitW-1:0] d,
    input logic [TableW-1:0] tbl_lo,
    input logic [TableW-1:0] tbl_hi
  );
    logic [SegW-1:0] seg;
    seg = SegInvalid;
    if (d < 4'd5) begin
      seg = tbl_lo[{d[2:0], 3'b000} +: SegW];
    end else if (d < 4'd10) begin
      seg = tbl_hi[{3'(d - 4'd5), 3'b000} +: SegW];
    end
    return seg;
  endfunction

endpackage

>>> rtl/core/ssd_bcd_cell.sv
// One decimal digit cell of the shift-and-add-3 converter.
// Depends on ssd_pkg for widths.
module ssd_bcd_cell (
  input  logic                       clk,
  input  logic                       clear,
  input  logic                       step,
  input  logic                       carry_in,
  output logic                       carry_out,
  output logic [ssd_pkg::DigitW-1:0] digit
);
  import ssd_pkg::*;

  logic [DigitW-1:0] adjusted;

  // add 3 before the shift so the doubled digit carries at ten
  assign adjusted  = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign carry_out = adjusted[DigitW-1];

  always_ff @(posedge clk) begin
    if (clear) begin
      digit <= '0;
    end else if (step) begin
      digit <= {adjusted[DigitW-2:0], carry_in};
    end
  end

endmodule

>>> rtl/core/ssd_bcd_chain.sv
// Binary to decimal converter: a row of digit cells fed MSB first from a shift register.
// Depends on ssd_pkg and ssd_bcd_cell.
module ssd_bcd_chain (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ssd_pkg::NumW-1:0] number,
  output ssd_pkg::digits_t         digits,
  output ssd_pkg::conv_status_t    status
);
  import ssd_pkg::*;

  logic [NumW-1:0]      shift_reg;
  logic [StepW-1:0]     steps_left;
  logic                 done;
  logic                 run;
  logic [MaxDigits:0]   carry;

  assign run      = (steps_left != '0);
  assign carry[0] = shift_reg[NumW-1];

  for (genvar i = 0; i < MaxDigits; i++) begin : g_cell
    ssd_bcd_cell u_cell (
      .clk       (clk),
      .clear     (start),
      .step      (run),
      .carry_in  (carry[i]),
      .carry_out (carry[i+1]),
      .digit     (digits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= '0;
      done       <= 1'b0;
    end else begin
      done <= run && (steps_left == StepW'(1));
      if (start) begin
        steps_left <= ConvSteps;
      end else if (run) begin
        steps_left <= steps_left - StepW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift_reg <= number;
    end else if (run) begin
      shift_reg <= {shift_reg[NumW-2:0], 1'b0};
    end
  end

  // carry out of the top cell is dropped: digits above the row are lost
  assign status.busy = run || done;
  assign status.done = done;

endmodule

>>> rtl/core/seven_segment_decimal_scan_driver.sv
// Top level of the multiplexed seven-segment driver: config, digit store, scan, output.
// Depends on ssd_pkg and ssd_bcd_chain.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------
//  item     | item_valid / item_stall   | action, number_value
//  result   | result_valid / result_stall | digit_select, segment_byte
//  config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A load request occupies the block while it loads the shift register, makes 27 shift
// steps through the digit cell row and writes the store. A scan request gives its
// result from the output register in the next cycle.
// item_stall is high while a conversion runs or a result waits under result_stall.
// Reset is synchronous; it clears the digit store and scan position and returns the
// config registers to their defaults.
module seven_segment_decimal_scan_driver (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic                        action,
  input  logic [ssd_pkg::NumW-1:0]    number_value,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [ssd_pkg::SegW-1:0]    digit_select,
  output logic [ssd_pkg::SegW-1:0]    segment_byte,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ssd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ssd_pkg::TableW-1:0]  cfg_data
);
  import ssd_pkg::*;

  logic [CountW-1:0] digit_count;
  logic              common_cathode;
  logic [TableW-1:0] table_lo;
  logic [TableW-1:0] table_hi;
  digits_t           digit_store;
  logic [PosW-1:0]   scan_pos;
  logic [PosW-1:0]   scan_pos_next;
  logic [CountW-1:0] count_eff;
  logic [PosW-1:0]   read_idx;
  logic [SegW-1:0]   seg_raw;
  logic [SegW-1:0]   sel_raw;
  logic              accept;
  logic              load_start;
  logic              scan_take;
  digits_t           conv_digits;
  conv_status_t      conv_status;

  ssd_bcd_chain u_chain (
    .clk    (clk),
    .rst    (rst),
    .start  (load_start),
    .number (number_value),
    .digits (conv_digits),
    .status (conv_status)
  );

  assign cfg_ready  = 1'b1;
  assign item_stall = conv_status.busy || (result_valid && result_stall);
  assign accept     = item_valid && !item_stall;
  assign load_start = accept && (action == ACTION_LOAD);
  assign scan_take  = accept && (action == ACTION_SCAN);

  // clamp the count to 1..MaxDigits
  always_comb begin
    priority if (digit_count == '0) begin
      count_eff = CountW'(1);
    end else if (digit_count > CountW'(MaxDigits)) begin
      count_eff = CountW'(MaxDigits);
    end else begin
      count_eff = digit_count;
    end
  end

  always_comb begin
    if ({1'b0, scan_pos} < count_eff - CountW'(1)) begin
      scan_pos_next = scan_pos + PosW'(1);
    end else begin
      scan_pos_next = '0;
    end
    read_idx = PosW'(count_eff - CountW'(1) - {1'b0, scan_pos_next});
    seg_raw  = segment_of(digit_store[read_idx], table_lo, table_hi);
    sel_raw  = SegW'(1) << scan_pos_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count    <= CountReset;
      common_cathode <= 1'b1;
      table_lo       <= TableLoReset;
      table_hi       <= TableHiReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DIGIT_COUNT:    digit_count    <= cfg_data[CountW-1:0];
        REG_COMMON_CATHODE: common_cathode <= cfg_data[0];
        REG_TABLE_LOW:      table_lo       <= cfg_data;
        REG_TABLE_HIGH:     table_hi       <= cfg_data;
        default: ;
      endcase
    end
  end

  // write only the digits in use; the rest keep their old values
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_store <= '0;
    end else if (conv_status.done) begin
      for (int i = 0; i < MaxDigits; i++) begin
        if (CountW'(i) < count_eff) begin
          digit_store[i] <= conv_digits[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pos     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (scan_take) begin
        scan_pos     <= scan_pos_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_take) begin
      digit_select <= common_cathode ? ~sel_raw : sel_raw;
      segment_byte <= common_cathode ? seg_raw : ~seg_raw;
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    conv_status.busy |-> item_stall)
    else $error("item taken during conversion");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    load_start |=> conv_status.busy && !conv_status.done)
    else $error("load request did not start conversion");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    conv_status.done |=> !conv_status.done)
    else $error("conversion done held longer than one cycle");

  a_select_onehot: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($onehot(digit_select) || $onehot(~digit_select)))
    else $error("digit select does not pick exactly one display");

endmodule
